// File: design/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// Types, register map and timing constants of the cache timing model.
// ----------------------------------------------------------------------------
package sact_pkg;

	localparam int unsigned CFG_ADDR_W = 5;

	// register byte addresses
	localparam logic [CFG_ADDR_W-1:0] REG_LOG2_SETS   = 5'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WAYS        = 5'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_LOG2_BLOCK  = 5'd8;
	localparam logic [CFG_ADDR_W-1:0] REG_WRITE_ALLOC = 5'd12;
	localparam logic [CFG_ADDR_W-1:0] REG_WRITE_THRU  = 5'd16;
	localparam logic [CFG_ADDR_W-1:0] REG_LRU_MODE    = 5'd20;

	localparam logic [15:0] WT_COST   = 16'd100;
	localparam logic [15:0] MAX_COST  = 16'hFFFF;
	localparam logic [3:0]  MAX_LOG2B = 4'd10;

	typedef enum logic [1:0] {
		CNT_LOAD_HIT   = 2'd0,
		CNT_LOAD_MISS  = 2'd1,
		CNT_STORE_HIT  = 2'd2,
		CNT_STORE_MISS = 2'd3
	} cnt_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch request, read the set
		logic update;   // write the set back, update counters
		logic present;  // load output register
		logic flush;    // start invalidation sweep
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic flush_busy;
	} dp_sts_t;

	// fill cost: 100 * 2^lb / 4
	function automatic logic [15:0] fill_cost(input logic [3:0] lb);
		logic [15:0] r;
		r = 16'd0;
		case (lb)
			4'd0:    r = 16'd25;
			4'd1:    r = 16'd50;
			4'd2:    r = 16'd100;
			4'd3:    r = 16'd200;
			4'd4:    r = 16'd400;
			4'd5:    r = 16'd800;
			4'd6:    r = 16'd1600;
			4'd7:    r = 16'd3200;
			4'd8:    r = 16'd6400;
			4'd9:    r = 16'd12800;
			default: r = 16'd25600;
		endcase
		return r;
	endfunction

endpackage

// File: design/sact_if.sv
// ----------------------------------------------------------------------------
// sact_req_if / sact_rsp_if
// Valid/ready channels for access requests and results.
// ----------------------------------------------------------------------------
interface sact_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] address;
	modport source (output valid, output op, output address, input ready);
	modport sink   (input valid, input op, input address, output ready);
endinterface

interface sact_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [15:0] access_cycles;
	logic [31:0] load_hit_count;
	logic [31:0] load_miss_count;
	logic [31:0] store_hit_count;
	logic [31:0] store_miss_count;
	logic [47:0] cycle_total;
	modport source (output valid, output hit, output access_cycles, output load_hit_count,
		output load_miss_count, output store_hit_count, output store_miss_count,
		output cycle_total, input ready);
	modport sink   (input valid, input hit, input access_cycles, input load_hit_count,
		input load_miss_count, input store_hit_count, input store_miss_count,
		input cycle_total, output ready);
endinterface

// File: design/sact_ctrl.sv
// ----------------------------------------------------------------------------
// sact_ctrl
// Controller: waits out invalidation sweeps and sequences lookup, update and result beat of one access.
// ----------------------------------------------------------------------------
module sact_ctrl
	import sact_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    geom_write,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [3:0] {
		ST_FLUSH  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_LOOKUP = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// output register may be reloaded when empty or taken this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && !sts.flush_busy;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && in_ready;
		cmd.update  = (state_q == ST_UPDATE) && out_free;
		cmd.present = cmd.update;
		cmd.flush   = geom_write;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FLUSH;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.present)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_FLUSH:  if (!sts.flush_busy) state_q <= ST_IDLE;
				ST_IDLE:   if (cmd.capture) state_q <= ST_LOOKUP;
				ST_LOOKUP: state_q <= ST_UPDATE;
				ST_UPDATE: if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	a_update_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOKUP |=> state_q == ST_UPDATE)
		else $error("lookup not followed by update");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.flush_busy |-> !in_ready)
		else $error("accepted during flush");
	a_present_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.present |=> out_valid_q)
		else $error("result beat lost");

endmodule

// File: design/sact_dp.sv
// ----------------------------------------------------------------------------
// sact_dp
// Datapath: tag memory, per-set state, tag compare, victim choice, costs
// and counters.
// ----------------------------------------------------------------------------
module sact_dp
	import sact_pkg::*;
#(
	parameter int unsigned MAX_SETS  = 256,
	parameter int unsigned MAX_WAYS  = 8,
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        req_op,
	input  logic [31:0] req_address,
	input  logic [3:0]  cfg_log2_sets,
	input  logic [3:0]  cfg_ways,
	input  logic [3:0]  cfg_log2_block,
	input  logic        cfg_write_alloc,
	input  logic        cfg_write_thru,
	input  logic        cfg_lru,
	output logic        hit,
	output logic [15:0] access_cycles,
	output logic [31:0] load_hit_count,
	output logic [31:0] load_miss_count,
	output logic [31:0] store_hit_count,
	output logic [31:0] store_miss_count,
	output logic [47:0] cycle_total
);

	localparam int unsigned LIM    = $clog2(MAX_SETS + 1) - 1;  // floor(log2)
	localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int unsigned ROW_W  = $clog2(MAX_SETS);
	localparam int unsigned ROW_IW = (ROW_W > 0) ? ROW_W : 1;
	localparam int unsigned TAG_W  = ADDR_BITS;

	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
	typedef logic [MAX_WAYS-1:0][WAY_W-1:0] age_row_t;

	// memories: one row per set, read and written whole
	tag_row_t tag_mem [MAX_SETS];
	logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
	logic [MAX_WAYS-1:0] dirty_mem [MAX_SETS];
	age_row_t age_mem [MAX_SETS];

	logic                op_q;
	logic [TAG_W-1:0]    tag_q;
	logic [ROW_IW-1:0]   set_q;
	tag_row_t            tag_rd_q;
	logic [MAX_WAYS-1:0] valid_rd_q, dirty_rd_q;
	age_row_t            age_rd_q;
	logic                flushing_q;
	logic [ROW_IW:0]     flush_ptr_q;
	logic [31:0]         cnt_q [4];
	logic [47:0]         total_q;

	// effective geometry
	logic [3:0]        ls, lb;
	logic [WCNT_W-1:0] nways;
	logic [ADDR_BITS-1:0] addr_m;
	logic [ADDR_BITS-1:0] set_full;
	logic [ROW_IW-1:0] set_idx;
	logic [TAG_W-1:0]  tag_c;

	always_comb begin
		ls = (cfg_log2_sets > 4'(LIM)) ? 4'(LIM) : cfg_log2_sets;
		lb = (cfg_log2_block > MAX_LOG2B) ? MAX_LOG2B : cfg_log2_block;
		if (cfg_ways == 4'd0)
			nways = WCNT_W'(1);
		else if ({28'd0, cfg_ways} > MAX_WAYS)
			nways = WCNT_W'(MAX_WAYS);
		else
			nways = WCNT_W'(cfg_ways);
		addr_m   = req_address[ADDR_BITS-1:0];
		set_full = (addr_m >> lb) & ((ADDR_BITS'(1) << ls) - ADDR_BITS'(1));
		set_idx  = ROW_IW'(set_full);
		// offset plus index reaches 18 bits, so widen the shift amount
		tag_c    = addr_m >> (5'(lb) + 5'(ls));
	end

	// flush sweep, one set per cycle
	assign sts.flush_busy = flushing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flushing_q  <= 1'b1;
			flush_ptr_q <= '0;
		end else if (cmd.flush) begin
			flushing_q  <= 1'b1;
			flush_ptr_q <= '0;
		end else if (flushing_q) begin
			if (flush_ptr_q == (ROW_IW+1)'(MAX_SETS - 1))
				flushing_q <= 1'b0;
			flush_ptr_q <= flush_ptr_q + 1'b1;
		end
	end

	// lookup evaluation on the registered row
	logic [MAX_WAYS-1:0] match;
	logic                hit_c;
	logic [WAY_W-1:0]    hit_way, vic_way, sel_way;
	logic                alloc, do_move;
	logic [15:0]         fill, cost;
	logic [17:0]         cost_w;
	tag_row_t            tag_nx;
	logic [MAX_WAYS-1:0] valid_nx, dirty_nx;
	age_row_t            age_nx;

	always_comb begin
		match   = '0;
		hit_c   = 1'b0;
		hit_way = '0;
		vic_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (WCNT_W'(w) < nways) begin
				match[w] = valid_rd_q[w] && (tag_rd_q[w] == tag_q);
				if (match[w]) begin
					hit_c   = 1'b1;
					hit_way = WAY_W'(w);
				end
			end
		end
		for (int w = 0; w < MAX_WAYS; w++)
			if (WCNT_W'(w) < nways && age_rd_q[w] == '0)
				vic_way = WAY_W'(w);
		alloc   = !hit_c && (!op_q || cfg_write_alloc);
		sel_way = hit_c ? hit_way : vic_way;
		do_move = hit_c ? cfg_lru : alloc;
		fill    = fill_cost(lb);

		cost_w = 18'd0;
		if (hit_c) begin
			cost_w = 18'd1;
			if (op_q)
				cost_w = cfg_write_thru ? 18'd1 + 18'(WT_COST) : 18'd2;
		end else begin
			if (alloc) begin
				cost_w = 18'(fill) + 18'd1;
				if (valid_rd_q[vic_way] && dirty_rd_q[vic_way])
					cost_w = cost_w + 18'(fill);
			end
			if (op_q && cfg_write_thru)
				cost_w = cost_w + 18'(WT_COST);
		end
		cost = (cost_w > 18'(MAX_COST)) ? MAX_COST : cost_w[15:0];

		tag_nx   = tag_rd_q;
		valid_nx = valid_rd_q;
		dirty_nx = dirty_rd_q;
		age_nx   = age_rd_q;
		if (alloc) begin
			tag_nx[vic_way]   = tag_q;
			valid_nx[vic_way] = 1'b1;
			dirty_nx[vic_way] = 1'b0;
		end
		if (op_q && !cfg_write_thru && (hit_c || alloc))
			dirty_nx[sel_way] = 1'b1;
		if (do_move) begin
			for (int w = 0; w < MAX_WAYS; w++)
				if (WCNT_W'(w) < nways && age_rd_q[w] > age_rd_q[sel_way])
					age_nx[w] = age_rd_q[w] - 1'b1;
			age_nx[sel_way] = WAY_W'(nways - 1'b1);
		end
	end

	// memory access: read on capture, write on update or flush
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= req_op;
			tag_q      <= tag_c;
			set_q      <= set_idx;
			tag_rd_q   <= tag_mem[set_idx];
			valid_rd_q <= valid_mem[set_idx];
			dirty_rd_q <= dirty_mem[set_idx];
			age_rd_q   <= age_mem[set_idx];
		end
		if (flushing_q) begin
			valid_mem[flush_ptr_q[ROW_IW-1:0]] <= '0;
			dirty_mem[flush_ptr_q[ROW_IW-1:0]] <= '0;
			for (int w = 0; w < MAX_WAYS; w++)
				age_mem[flush_ptr_q[ROW_IW-1:0]][w] <= WAY_W'(w);
		end else if (cmd.update) begin
			tag_mem[set_q]   <= tag_nx;
			valid_mem[set_q] <= valid_nx;
			dirty_mem[set_q] <= dirty_nx;
			age_mem[set_q]   <= age_nx;
		end
	end

	// counters
	logic [1:0]  csel;
	logic [48:0] tot_sum;
	assign csel    = op_q ? (hit_c ? CNT_STORE_HIT : CNT_STORE_MISS)
		: (hit_c ? CNT_LOAD_HIT : CNT_LOAD_MISS);
	assign tot_sum = {1'b0, total_q} + 49'(cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
			total_q <= '0;
		end else if (cmd.update) begin
			if (cnt_q[csel] != 32'hFFFF_FFFF)
				cnt_q[csel] <= cnt_q[csel] + 32'd1;
			total_q <= tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.present) begin
			hit           <= hit_c;
			access_cycles <= cost;
			cycle_total   <= tot_sum[48] ? 48'hFFFF_FFFF_FFFF : tot_sum[47:0];
			load_hit_count   <= cnt_q[CNT_LOAD_HIT] +
				32'((csel == CNT_LOAD_HIT) && cnt_q[CNT_LOAD_HIT] != 32'hFFFF_FFFF);
			load_miss_count  <= cnt_q[CNT_LOAD_MISS] +
				32'((csel == CNT_LOAD_MISS) && cnt_q[CNT_LOAD_MISS] != 32'hFFFF_FFFF);
			store_hit_count  <= cnt_q[CNT_STORE_HIT] +
				32'((csel == CNT_STORE_HIT) && cnt_q[CNT_STORE_HIT] != 32'hFFFF_FFFF);
			store_miss_count <= cnt_q[CNT_STORE_MISS] +
				32'((csel == CNT_STORE_MISS) && cnt_q[CNT_STORE_MISS] != 32'hFFFF_FFFF);
		end
	end

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $onehot0(match))
		else $error("tag present in two ways");
	a_no_update_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !flushing_q)
		else $error("update during flush");
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> total_q >= $past(total_q))
		else $error("cycle total went down");

endmodule

// File: design/set_assoc_cache_timing_model.sv
// An accepted request passes through capture and set read, compare and cost,
// and the result register, which loads only when the output register is free.
// A new access is accepted only after the previous one has written back the
// per-set tag and state memory and the controller is idle again.
// Reset, and any write to log2_sets, ways_in_use or log2_block_bytes, runs an
// invalidation sweep over all MAX_SETS sets during which no request is accepted.
// ----------------------------------------------------------------------------
// set_assoc_cache_timing_model
// Set-associative cache timing model with APB register port.
// ----------------------------------------------------------------------------
module set_assoc_cache_timing_model
	import sact_pkg::*;
#(
	parameter int unsigned MAX_SETS  = 256,
	parameter int unsigned MAX_WAYS  = 8,
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sact_req_if.sink              req,
	sact_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [3:0] log2_sets_q, ways_q, log2_block_q;
	logic       walloc_q, wthru_q, lru_q;
	logic       wr_en, geom_write;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign geom_write = wr_en && (paddr == REG_LOG2_SETS || paddr == REG_WAYS
		|| paddr == REG_LOG2_BLOCK);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_sets_q  <= 4'd0;
			ways_q       <= 4'd1;
			log2_block_q <= 4'd4;
			walloc_q     <= 1'b1;
			wthru_q      <= 1'b0;
			lru_q        <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr)
				REG_LOG2_SETS:   log2_sets_q  <= pwdata[3:0];
				REG_WAYS:        ways_q       <= pwdata[3:0];
				REG_LOG2_BLOCK:  log2_block_q <= pwdata[3:0];
				REG_WRITE_ALLOC: walloc_q     <= pwdata[0];
				REG_WRITE_THRU:  wthru_q      <= pwdata[0];
				REG_LRU_MODE:    lru_q        <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr)
			REG_LOG2_SETS:   prdata = {28'd0, log2_sets_q};
			REG_WAYS:        prdata = {28'd0, ways_q};
			REG_LOG2_BLOCK:  prdata = {28'd0, log2_block_q};
			REG_WRITE_ALLOC: prdata = {31'd0, walloc_q};
			REG_WRITE_THRU:  prdata = {31'd0, wthru_q};
			REG_LRU_MODE:    prdata = {31'd0, lru_q};
			default:         prdata = 32'd0;
		endcase
	end

	sact_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.geom_write (geom_write),
		.cmd        (cmd),
		.sts        (sts)
	);

	sact_dp #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_op           (req.op),
		.req_address      (req.address),
		.cfg_log2_sets    (log2_sets_q),
		.cfg_ways         (ways_q),
		.cfg_log2_block   (log2_block_q),
		.cfg_write_alloc  (walloc_q),
		.cfg_write_thru   (wthru_q),
		.cfg_lru          (lru_q),
		.hit              (rsp.hit),
		.access_cycles    (rsp.access_cycles),
		.load_hit_count   (rsp.load_hit_count),
		.load_miss_count  (rsp.load_miss_count),
		.store_hit_count  (rsp.store_hit_count),
		.store_miss_count (rsp.store_miss_count),
		.cycle_total      (rsp.cycle_total)
	);

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives loads and stores into the cache timing model across a range of
// geometries and write policies, and checks every result beat field by field
// against a behavioural cache model kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module testbench;
	import sact_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSETS = 256;
	localparam int NWAYS = 8;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sact_req_if req ();
	sact_rsp_if rsp ();

	set_assoc_cache_timing_model dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct packed {
		logic        hit;
		logic [15:0] access_cycles;
		logic [31:0] load_hit_count;
		logic [31:0] load_miss_count;
		logic [31:0] store_hit_count;
		logic [31:0] store_miss_count;
		logic [47:0] cycle_total;
	} access_result_t;

	// one directed access; chk_hit < 0 means predictor only
	typedef struct {
		logic        op;
		logic [31:0] address;
		int          chk_hit;
		int          chk_cyc;
	} probe_t;

	// cache mirror
	logic [3:0]  cfg_sets, cfg_ways, cfg_block;
	logic        cfg_alloc, cfg_wthru, cfg_lru;
	logic [31:0] line_tag [NSETS*NWAYS];
	logic        line_valid [NSETS*NWAYS];
	logic        line_dirty [NSETS*NWAYS];
	logic [2:0]  line_age [NSETS*NWAYS];
	logic [31:0] tally [4];
	logic [47:0] cycles_sum;

	access_result_t expected_results[$];
	int  n_errors;
	bit  stim_done;
	int  hold_cycles = 0;
	int  n_sent = 0;

	function automatic void invalidate_lines();
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_age[i] = 3'(i % NWAYS);
		end
	endfunction

	function automatic void promote(int unsigned base, int unsigned n, int unsigned w);
		logic [2:0] r;
		r = line_age[base+w];
		for (int i = 0; i < n; i++)
			if (line_age[base+i] > r) line_age[base+i] = line_age[base+i] - 3'd1;
		line_age[base+w] = 3'(n - 1);
	endfunction

	function automatic void count(cnt_sel_t c);
		if (tally[c] != 32'hFFFF_FFFF) tally[c] = tally[c] + 32'd1;
	endfunction

	// predicted outcome of one access; updates the mirror
	function automatic access_result_t cache_access(logic is_store, logic [31:0] addr);
		int unsigned ls, lb, n, fill, set_i, base, vway, way;
		logic [31:0] tg;
		logic [63:0] cost;
		logic [48:0] sum;
		logic hit, alloc;
		access_result_t r;
		ls = (cfg_sets > 8) ? 8 : cfg_sets;
		lb = (cfg_block > 10) ? 10 : cfg_block;
		n = (cfg_ways < 1) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
		fill = (100 << lb) >> 2;
		set_i = (addr >> lb) & ((1 << ls) - 1);
		tg = 32'(64'(addr) >> (lb + ls));
		base = set_i * NWAYS;
		hit = 1'b0;
		way = 0;
		cost = 0;
		for (int w = 0; w < n; w++)
			if (!hit && line_valid[base+w] && line_tag[base+w] == tg) begin
				hit = 1'b1;
				way = w;
			end
		if (hit) begin
			if (cfg_lru) promote(base, n, way);
			cost = 1;
			if (is_store) begin
				if (cfg_wthru) cost += 100;
				else begin
					line_dirty[base+way] = 1'b1;
					cost += 1;
				end
			end
			count(is_store ? CNT_STORE_HIT : CNT_LOAD_HIT);
		end else begin
			alloc = !is_store || cfg_alloc;
			if (alloc) begin
				vway = 0;
				for (int w = 0; w < n; w++) if (line_age[base+w] == 0) vway = w;
				cost += fill + 1;
				if (line_valid[base+vway] && line_dirty[base+vway]) cost += fill;
				line_tag[base+vway] = tg;
				line_valid[base+vway] = 1'b1;
				line_dirty[base+vway] = 1'b0;
				promote(base, n, vway);
				way = vway;
			end
			if (is_store) begin
				if (cfg_wthru) cost += 100;
				else if (alloc) line_dirty[base+way] = 1'b1;
			end
			count(is_store ? CNT_STORE_MISS : CNT_LOAD_MISS);
		end
		if (cost > 64'hFFFF) cost = 64'hFFFF;
		sum = {1'b0, cycles_sum} + 49'(cost);
		cycles_sum = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
		r.hit = hit;
		r.access_cycles = cost[15:0];
		r.load_hit_count = tally[CNT_LOAD_HIT];
		r.load_miss_count = tally[CNT_LOAD_MISS];
		r.store_hit_count = tally[CNT_STORE_HIT];
		r.store_miss_count = tally[CNT_STORE_MISS];
		r.cycle_total = cycles_sum;
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// limit
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// APB write: setup then access
	task automatic reg_write(logic [CFG_ADDR_W-1:0] a, logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			REG_LOG2_SETS: begin
				cfg_sets = d[3:0];
				invalidate_lines();
			end
			REG_WAYS: begin
				cfg_ways = d[3:0];
				invalidate_lines();
			end
			REG_LOG2_BLOCK: begin
				cfg_block = d[3:0];
				invalidate_lines();
			end
			REG_WRITE_ALLOC: cfg_alloc = d[0];
			REG_WRITE_THRU:  cfg_wthru = d[0];
			REG_LRU_MODE:    cfg_lru = d[0];
			default: ;
		endcase
	endtask

	// present one request beat with a random gap before it; valid stays up
	// after the beat so that back-to-back beats need no second drive
	task automatic send_access(logic is_store, logic [31:0] addr);
		int  gap;
		bit  taken;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= is_store;
		req.address <= addr;
		n_sent++;
		// ready only moves at the rising edge, so the falling edge shows it
		do begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end while (!taken);
		expected_results.push_back(cache_access(is_store, addr));
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// random geometry and policies, extremes favoured
	task automatic random_config();
		reg_write(REG_LOG2_SETS, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(9, 15)) :
			32'($urandom_range(0, 4)));
		reg_write(REG_WAYS, ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 15)) :
			32'($urandom_range(1, 4)));
		reg_write(REG_LOG2_BLOCK, 32'($urandom_range(0, 15)));
		reg_write(REG_WRITE_ALLOC, $urandom);
		reg_write(REG_WRITE_THRU, $urandom);
		reg_write(REG_LRU_MODE, $urandom);
	endtask

	// stimulus
	initial begin
		probe_t probes[$];
		access_result_t got;
		logic [31:0] pool[16];
		logic [31:0] a;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = 1'b0;
		req.address = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_sets = 4'd0;
		cfg_ways = 4'd1;
		cfg_block = 4'd4;
		cfg_alloc = 1'b1;
		cfg_wthru = 1'b0;
		cfg_lru = 1'b1;
		for (int i = 0; i < 4; i++) tally[i] = '0;
		cycles_sum = '0;
		invalidate_lines();
		n_errors = 0;
		stim_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings (1 set, 1 way, 16-byte blocks, WB, alloc)
		probes = '{
			'{1'b0, 32'h0000_0000, 0, 401},
			'{1'b0, 32'h0000_000F, 1, 1},
			'{1'b1, 32'h0000_0004, 1, 2},
			'{1'b0, 32'hFFFF_FFFF, 0, 801},
			'{1'b1, 32'h0000_0010, 0, 401},
			'{1'b1, 32'h0000_0010, 1, 2},
			'{1'b0, 32'hFFFF_FFF0, 0, 801},
			'{1'b0, 32'h8000_0000, 0, 401},
			'{1'b0, 32'h7FFF_FFFF, -1, -1},
			'{1'b1, 32'hAAAA_5555, -1, -1}
		};
		foreach (probes[i]) begin
			send_access(probes[i].op, probes[i].address);
			got = expected_results[$];
			if (probes[i].chk_hit >= 0 && (int'(got.hit) != probes[i].chk_hit ||
					int'(got.access_cycles) != probes[i].chk_cyc)) begin
				$error("table row %0d: hit %0d cycles %0d, typed %0d %0d", i, got.hit,
					got.access_cycles, probes[i].chk_hit, probes[i].chk_cyc);
				n_errors++;
			end
		end
		drain();

		// extremes: large sets/blocks, out of range ways, write-through no-allocate, FIFO
		reg_write(REG_LOG2_SETS, 32'hFFFF_FFFF);
		reg_write(REG_WAYS, 32'd0);
		reg_write(REG_LOG2_BLOCK, 32'd15);
		reg_write(REG_WRITE_ALLOC, 32'd0);
		reg_write(REG_WRITE_THRU, 32'd1);
		reg_write(REG_LRU_MODE, 32'd0);
		send_access(1'b1, 32'h0000_0000);
		send_access(1'b0, 32'hFFFF_FFFF);
		send_access(1'b1, 32'hFFFF_FFFF);
		send_access(1'b0, 32'h0000_0400);
		drain();
		reg_write(REG_WAYS, 32'd15);
		reg_write(REG_LOG2_BLOCK, 32'd0);
		reg_write(REG_LOG2_SETS, 32'd8);
		reg_write(REG_WRITE_THRU, 32'd0);
		reg_write(REG_LOG2_BLOCK, 32'd1);
		for (int i = 0; i < 10; i++) send_access(1'(i), 32'(i) << 9);
		send_access(1'b0, 32'h0);
		drain();

		// random phases: mostly a small working set per phase to get hits and evictions
		for (int ph = 0; ph < 14; ph++) begin
			random_config();
			foreach (pool[k]) pool[k] = $urandom;
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 5) == 0) a = $urandom;
				else a = pool[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 3));
				send_access(1'($urandom), a);
			end
			drain();
		end
		stim_done = 1'b1;
	end

	// result side: random stalls, and no ready at all during the long hold-off
	initial begin
		int w;
		bit taken;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 5);
			if (w > 0 || hold_cycles != 0) begin
				rsp.ready <= 1'b0;
				repeat (w) @(posedge clk);
				while (hold_cycles != 0) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			// valid only moves at the rising edge, so the falling edge shows it
			do begin
				@(negedge clk);
				taken = rsp.valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (n_sent >= 100);
		force_hold();
	end

	task automatic force_hold();
		@(posedge clk);
		hold_cycles = 1;
		while (hold_cycles < 200) begin
			@(posedge clk);
			hold_cycles++;
		end
		hold_cycles = 0;
	endtask

	// checker
	always @(posedge clk) begin
		access_result_t exp_r;
		if (rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				n_errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp.hit !== exp_r.hit) begin
					$error("hit: expected %0d, got %0d", exp_r.hit, rsp.hit);
					n_errors++;
				end
				if (rsp.access_cycles !== exp_r.access_cycles) begin
					$error("access_cycles: expected %0d, got %0d", exp_r.access_cycles,
						rsp.access_cycles);
					n_errors++;
				end
				if (rsp.load_hit_count !== exp_r.load_hit_count) begin
					$error("load_hit_count: expected %0d, got %0d", exp_r.load_hit_count,
						rsp.load_hit_count);
					n_errors++;
				end
				if (rsp.load_miss_count !== exp_r.load_miss_count) begin
					$error("load_miss_count: expected %0d, got %0d", exp_r.load_miss_count,
						rsp.load_miss_count);
					n_errors++;
				end
				if (rsp.store_hit_count !== exp_r.store_hit_count) begin
					$error("store_hit_count: expected %0d, got %0d", exp_r.store_hit_count,
						rsp.store_hit_count);
					n_errors++;
				end
				if (rsp.store_miss_count !== exp_r.store_miss_count) begin
					$error("store_miss_count: expected %0d, got %0d", exp_r.store_miss_count,
						rsp.store_miss_count);
					n_errors++;
				end
				if (rsp.cycle_total !== exp_r.cycle_total) begin
					$error("cycle_total: expected %0d, got %0d", exp_r.cycle_total,
						rsp.cycle_total);
					n_errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		if (n_errors == 0 && expected_results.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
